// ----- design/truncated_pivoted_lu_assert.svh -----
// assertion macros for the pivoted lu block
`ifndef TRUNCATED_PIVOTED_LU_ASSERT_SVH
`define TRUNCATED_PIVOTED_LU_ASSERT_SVH

// same-cycle implication
`define TPLU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TPLU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/tplu_pkg.sv -----
// types and constants of the pivoted lu block
package tplu_pkg;

	localparam int MAX_ROWS_D   = 8;
	localparam int MAX_COLS_D   = 8;
	localparam int DATA_WIDTH_D = 32;
	localparam int ELEM_W       = 32;
	localparam int FRAC_W       = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_ROWS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_MIN = 3'd4;

	typedef struct packed {
		logic signed [ELEM_W-1:0] elem_value;
		logic                     elem_last;
	} elem_in_t;

	typedef struct packed {
		logic [2:0]               out_row;
		logic [2:0]               out_col;
		logic signed [ELEM_W-1:0] out_value;
		logic [2:0]               orig_row;
		logic [3:0]               steps_done;
		logic                     out_last;
	} result_t;

endpackage

// ----- design/tplu_ram.sv -----
// generic ram with one write port and one registered read port
module tplu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/truncated_pivoted_lu.sv -----
// top level of the pivoted lu block: loader, elimination sequencer and result emitter
//
// channel | direction | handshake              | item
// in      | input     | in_valid / in_ready    | one matrix element, row-major
// out     | output    | out_valid / out_ready  | one packed factor element
// cfg     | input     | cfg_we                 | one register write
//
// loading takes one cycle per element; the item with elem_last starts factoring
// each step searches for the pivot row, swaps it in column by column, scales the rows
// below (one shared restoring divider) and updates the rest (one multiplier)
// results go out through an output register, one element at a time, each held until taken
// in_ready is low from the last element until the final result is taken
// reset initialises control state and config; the matrix memory is not cleared
module truncated_pivoted_lu #(
	parameter int MAX_ROWS   = tplu_pkg::MAX_ROWS_D,
	parameter int MAX_COLS   = tplu_pkg::MAX_COLS_D,
	parameter int DATA_WIDTH = tplu_pkg::DATA_WIDTH_D
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  tplu_pkg::elem_in_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output tplu_pkg::result_t                  out_data,
	input  logic                               cfg_we,
	input  logic [tplu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tplu_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int NW  = $clog2(MAX_ROWS + 1);
	localparam int CW  = NW + 4;
	localparam int RIW = $clog2(MAX_ROWS);
	localparam int AW  = $clog2(MAX_ROWS * MAX_COLS);
	localparam int EW  = tplu_pkg::ELEM_W;
	localparam int FW  = tplu_pkg::FRAC_W;
	localparam int QW  = EW + FW;
	localparam int DCW = $clog2(QW);
	localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (DATA_WIDTH - 1)) - 66'sd1;
	localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;

	typedef enum logic [4:0] {
		S_IDLE, S_STEP, S_SR_RD, S_SR_CMP, S_SW_RO, S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB,
		S_PV_RD, S_PV_CHK, S_SC_RD, S_SC_LD, S_SC_DIV, S_SC_WR,
		S_UP_RL, S_UP_RU, S_UP_RA, S_UP_MUL, S_UP_WR, S_AFTER,
		S_EM_RD, S_EM_LD, S_EM_OUT
	} state_t;

	state_t state_q;

	logic [3:0]  rows_cfg_q, cols_cfg_q, max_steps_q, init_rows_q;
	logic [15:0] pivot_min_q;

	logic [NW-1:0] load_r_q, load_c_q;
	logic [NW-1:0] k_q, i_q, j_q, piv_q, step_q;
	logic [EW:0]   best_q;
	logic [2:0]    row_order_q [MAX_ROWS];
	logic signed [EW-1:0] ta_q, p_q, l_q, u_q, a_q;
	logic signed [63:0]   prod_q;
	logic [QW-1:0]  dvd_q;
	logic [EW:0]    rem_q;
	logic [EW-1:0]  dvs_q;
	logic           neg_q;
	logic [DCW-1:0] dcnt_q;
	tplu_pkg::result_t out_q;

	logic [NW-1:0] rows_e, cols_e, kmax_e, init_e, end_e;
	logic [CW-1:0] rr, cc, ks, ir;

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [EW-1:0] mem_wdata, mem_rdata;
	logic [EW-1:0] rd_mag;
	logic [EW:0]   rem_sh;
	logic signed [65:0] quo_s, upd_s;
	logic [63:0]   pmag, pshift;

	function automatic logic [AW-1:0] addr_of(input logic [NW-1:0] r, input logic [NW-1:0] c);
		return AW'(r * MAX_COLS + c);
	endfunction

	function automatic logic [EW-1:0] mag_f(input logic [EW-1:0] x);
		return x[EW-1] ? (~x + 1'b1) : x;
	endfunction

	function automatic logic [EW-1:0] sat_f(input logic signed [65:0] x);
		if (x > SAT_HI) begin
			return SAT_HI[EW-1:0];
		end
		if (x < SAT_LO) begin
			return SAT_LO[EW-1:0];
		end
		return x[EW-1:0];
	endfunction

	always_comb begin
		rr = CW'(rows_cfg_q);
		if (rr == '0) rr = CW'(1);
		if (int'(rr) > MAX_ROWS) rr = CW'(MAX_ROWS);
		cc = CW'(cols_cfg_q);
		if (cc == '0) cc = CW'(1);
		if (int'(cc) > MAX_COLS) cc = CW'(MAX_COLS);
		if (cc > rr) cc = rr;
		ks = CW'(max_steps_q);
		if (ks > rr) ks = rr;
		ir = CW'(init_rows_q);
		if (ir > rr) ir = rr;
		rows_e = NW'(rr);
		cols_e = NW'(cc);
		kmax_e = NW'(ks);
		init_e = NW'(ir);
		end_e  = (k_q < init_e) ? init_e : rows_e;
	end

	assign rd_mag = mag_f(mem_rdata);
	assign rem_sh = {rem_q[EW-1:0], dvd_q[QW-1]};
	assign quo_s  = neg_q ? -$signed(66'(dvd_q)) : $signed(66'(dvd_q));
	assign pmag   = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
	assign pshift = pmag >> FW;
	assign upd_s  = 66'(a_q) - (prod_q[63] ? -$signed(66'(pshift)) : $signed(66'(pshift)));

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_of(load_r_q, load_c_q);
		mem_wdata = in_data.elem_value;
		mem_raddr = addr_of(i_q, k_q);
		case (state_q)
			S_IDLE: begin
				mem_we = in_valid && (load_r_q < rows_e);
			end
			S_SW_RA: mem_raddr = addr_of(k_q, j_q);
			S_SW_RB: mem_raddr = addr_of(piv_q, j_q);
			S_SW_WA: begin
				mem_we    = 1'b1;
				mem_waddr = addr_of(k_q, j_q);
				mem_wdata = mem_rdata;
			end
			S_SW_WB: begin
				mem_we    = 1'b1;
				mem_waddr = addr_of(piv_q, j_q);
				mem_wdata = ta_q;
			end
			S_PV_RD: mem_raddr = addr_of(k_q, k_q);
			S_SC_WR: begin
				mem_we    = 1'b1;
				mem_waddr = addr_of(i_q, k_q);
				mem_wdata = sat_f(quo_s);
			end
			S_UP_RU: mem_raddr = addr_of(k_q, j_q);
			S_UP_RA: mem_raddr = addr_of(i_q, j_q);
			S_UP_WR: begin
				mem_we    = 1'b1;
				mem_waddr = addr_of(i_q, j_q);
				mem_wdata = sat_f(upd_s);
			end
			S_EM_RD: mem_raddr = addr_of(i_q, j_q);
			default: ;
		endcase
	end

	tplu_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_ROWS * MAX_COLS)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rows_cfg_q  <= 4'd8;
			cols_cfg_q  <= 4'd8;
			max_steps_q <= 4'd8;
			init_rows_q <= 4'd0;
			pivot_min_q <= 16'd1;
			load_r_q    <= '0;
			load_c_q    <= '0;
			k_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			piv_q       <= '0;
			step_q      <= '0;
			for (int n = 0; n < MAX_ROWS; n++) begin
				row_order_q[n] <= 3'(n);
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tplu_pkg::CFG_ROWS:      rows_cfg_q  <= cfg_data[3:0];
					tplu_pkg::CFG_COLS:      cols_cfg_q  <= cfg_data[3:0];
					tplu_pkg::CFG_MAX_STEPS: max_steps_q <= cfg_data[3:0];
					tplu_pkg::CFG_INIT_ROWS: init_rows_q <= cfg_data[3:0];
					tplu_pkg::CFG_PIVOT_MIN: pivot_min_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (load_r_q < rows_e) begin
							if (load_c_q + 1'b1 >= cols_e) begin
								load_c_q <= '0;
								load_r_q <= load_r_q + 1'b1;
							end else begin
								load_c_q <= load_c_q + 1'b1;
							end
						end
						if (in_data.elem_last) begin
							load_r_q <= '0;
							load_c_q <= '0;
							k_q      <= '0;
							for (int n = 0; n < MAX_ROWS; n++) begin
								row_order_q[n] <= 3'(n);
							end
							state_q <= S_STEP;
						end
					end
				end
				S_STEP: begin
					piv_q   <= k_q;
					best_q  <= '0;
					i_q     <= k_q;
					state_q <= S_SR_RD;
				end
				S_SR_RD: state_q <= S_SR_CMP;
				S_SR_CMP: begin
					if ({1'b0, rd_mag} > best_q) begin
						best_q <= {1'b0, rd_mag};
						piv_q  <= i_q;
					end
					if (i_q + 1'b1 < end_e) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SR_RD;
					end else begin
						state_q <= S_SW_RO;
					end
				end
				S_SW_RO: begin
					row_order_q[k_q[RIW-1:0]]   <= row_order_q[piv_q[RIW-1:0]];
					row_order_q[piv_q[RIW-1:0]] <= row_order_q[k_q[RIW-1:0]];
					j_q     <= '0;
					state_q <= S_SW_RA;
				end
				S_SW_RA: state_q <= S_SW_RB;
				S_SW_RB: begin
					ta_q    <= mem_rdata;
					state_q <= S_SW_WA;
				end
				S_SW_WA: state_q <= S_SW_WB;
				S_SW_WB: begin
					if (j_q + 1'b1 < cols_e) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_SW_RA;
					end else begin
						state_q <= S_PV_RD;
					end
				end
				S_PV_RD: state_q <= S_PV_CHK;
				S_PV_CHK: begin
					p_q <= mem_rdata;
					i_q <= k_q + 1'b1;
					if (mem_rdata == '0 || rd_mag < EW'(pivot_min_q)) begin
						step_q  <= k_q;
						i_q     <= '0;
						j_q     <= '0;
						state_q <= S_EM_RD;
					end else if (k_q + 1'b1 < rows_e) begin
						state_q <= S_SC_RD;
					end else begin
						state_q <= S_AFTER;
					end
				end
				S_SC_RD: state_q <= S_SC_LD;
				S_SC_LD: begin
					dvd_q   <= {rd_mag, {FW{1'b0}}};
					dvs_q   <= mag_f(p_q);
					rem_q   <= '0;
					neg_q   <= mem_rdata[EW-1] ^ p_q[EW-1];
					dcnt_q  <= '0;
					state_q <= S_SC_DIV;
				end
				S_SC_DIV: begin
					if (rem_sh >= {1'b0, dvs_q}) begin
						rem_q <= rem_sh - {1'b0, dvs_q};
						dvd_q <= {dvd_q[QW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						dvd_q <= {dvd_q[QW-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCW'(QW - 1)) begin
						state_q <= S_SC_WR;
					end
				end
				S_SC_WR: begin
					if (i_q + 1'b1 < rows_e) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SC_RD;
					end else begin
						i_q <= k_q + 1'b1;
						j_q <= k_q + 1'b1;
						state_q <= (k_q + 1'b1 < cols_e) ? S_UP_RL : S_AFTER;
					end
				end
				S_UP_RL: state_q <= S_UP_RU;
				S_UP_RU: begin
					l_q     <= mem_rdata;
					state_q <= S_UP_RA;
				end
				S_UP_RA: begin
					u_q     <= mem_rdata;
					state_q <= S_UP_MUL;
				end
				S_UP_MUL: begin
					a_q     <= mem_rdata;
					prod_q  <= l_q * u_q;
					state_q <= S_UP_WR;
				end
				S_UP_WR: begin
					if (j_q + 1'b1 < cols_e) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_UP_RL;
					end else if (i_q + 1'b1 < rows_e) begin
						i_q     <= i_q + 1'b1;
						j_q     <= k_q + 1'b1;
						state_q <= S_UP_RL;
					end else begin
						state_q <= S_AFTER;
					end
				end
				S_AFTER: begin
					i_q <= '0;
					j_q <= '0;
					if (k_q >= kmax_e) begin
						step_q  <= k_q;
						state_q <= S_EM_RD;
					end else if (k_q + 1'b1 >= cols_e) begin
						step_q  <= cols_e;
						state_q <= S_EM_RD;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_STEP;
					end
				end
				S_EM_RD: state_q <= S_EM_LD;
				S_EM_LD: begin
					out_q.out_row    <= 3'(i_q);
					out_q.out_col    <= 3'(j_q);
					out_q.out_value  <= mem_rdata;
					out_q.orig_row   <= row_order_q[i_q[RIW-1:0]];
					out_q.steps_done <= 4'(step_q);
					out_q.out_last   <= (i_q + 1'b1 == rows_e) && (j_q + 1'b1 == cols_e);
					state_q          <= S_EM_OUT;
				end
				S_EM_OUT: begin
					if (out_ready) begin
						if (out_q.out_last) begin
							state_q <= S_IDLE;
						end else begin
							if (j_q + 1'b1 < cols_e) begin
								j_q <= j_q + 1'b1;
							end else begin
								j_q <= '0;
								i_q <= i_q + 1'b1;
							end
							state_q <= S_EM_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EM_OUT);
	assign out_data  = out_q;

`include "truncated_pivoted_lu_assert.svh"

	`TPLU_ASSERT_SAME(a_no_overlap, clk, arst_n, 1'b1, !(in_ready && out_valid),
		"input taken while a result is pending")
	`TPLU_ASSERT_NEXT(a_last_idle, clk, arst_n, out_valid && out_ready && out_data.out_last,
		in_ready, "block not idle after final result")
	`TPLU_ASSERT_SAME(a_piv_range, clk, arst_n, state_q == S_SW_RA, piv_q >= k_q,
		"pivot row above current step")

endmodule

// ----- dv/truncated_pivoted_lu_tb.sv -----
// testbench of the pivoted lu block: directed and random matrices checked against a fixed-point predictor
`timescale 1ns / 100ps

module truncated_pivoted_lu_tb;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int ITEM_TARGET = 430;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 40;
	localparam int HOLD_RUN    = 3;

	typedef struct {
		bit          newcfg;
		logic [3:0]  r, c, s, ir;
		logic [15:0] pm;
		logic [31:0] v;
		bit          last;
		bit          chk;
		logic [31:0] xv;
		logic [3:0]  xs;
	} dir_row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_we;
	tplu_pkg::elem_in_t in_data;
	tplu_pkg::result_t out_data;
	logic [tplu_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tplu_pkg::CFG_DATA_W-1:0] cfg_data;

	logic [3:0] rows_reg, cols_reg, steps_reg, init_reg;
	logic [15:0] pmin_reg;
	longint lu_mat [64];
	bit written [64];
	logic [2:0] perm [8];
	int load_cnt;
	tplu_pkg::result_t factor_q [$];

	int errors, n_items, cycles;
	bit quiet, hold_req;
	int hold_cnt, rdy_burst;

	dir_row_t dir_tab [16] = '{
		'{1, 1, 1, 8, 0, 16'h0001, 32'h7FFF_FFFF, 1, 1, 32'h7FFF_FFFF, 4'd1},
		'{0, 0, 0, 0, 0, 16'h0000, 32'h0000_0000, 1, 1, 32'h0000_0000, 4'd0},
		'{0, 0, 0, 0, 0, 16'h0000, 32'h8000_0000, 1, 1, 32'h8000_0000, 4'd1},
		'{1, 1, 1, 8, 0, 16'hFFFF, 32'h0000_FFFF, 1, 1, 32'h0000_FFFF, 4'd1},
		'{0, 0, 0, 0, 0, 16'h0000, 32'h0000_FFFE, 1, 1, 32'h0000_FFFE, 4'd0},
		'{1, 2, 2, 8, 0, 16'h0001, 32'h0001_0000, 0, 0, 32'h0, 4'd0},
		'{0, 0, 0, 0, 0, 16'h0000, 32'h0002_0000, 0, 0, 32'h0, 4'd0},
		'{0, 0, 0, 0, 0, 16'h0000, 32'h0003_0000, 0, 0, 32'h0, 4'd0},
		'{0, 0, 0, 0, 0, 16'h0000, 32'h0004_0000, 1, 0, 32'h0, 4'd0},
		'{0, 0, 0, 0, 0, 16'h0000, 32'h7FFF_FFFF, 0, 0, 32'h0, 4'd0},
		'{0, 0, 0, 0, 0, 16'h0000, 32'h8000_0000, 0, 0, 32'h0, 4'd0},
		'{0, 0, 0, 0, 0, 16'h0000, 32'h0000_0001, 0, 0, 32'h0, 4'd0},
		'{0, 0, 0, 0, 0, 16'h0000, 32'hFFFF_FFFF, 0, 0, 32'h0, 4'd0},
		'{0, 0, 0, 0, 0, 16'h0000, 32'h1234_5678, 1, 0, 32'h0, 4'd0},
		'{1, 2, 2, 0, 2, 16'h0000, 32'h0002_0000, 1, 0, 32'h0, 4'd0},
		'{1, 0, 0, 15, 15, 16'h0000, 32'h0000_0000, 1, 0, 32'h0, 4'd0}
	};

	truncated_pivoted_lu dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles == CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic int eff_rows();
		int r;
		r = int'(rows_reg);
		if (r < 1) r = 1;
		if (r > 8) r = 8;
		return r;
	endfunction

	function automatic int eff_cols(int r);
		int c;
		c = int'(cols_reg);
		if (c < 1) c = 1;
		if (c > 8) c = 8;
		if (c > r) c = r;
		return c;
	endfunction

	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint magn(longint x);
		return x < 0 ? -x : x;
	endfunction

	function automatic longint qmul(longint a, longint b);
		longint p;
		p = a * b;
		return p < 0 ? -((-p) >> 16) : (p >> 16);
	endfunction

	task automatic lu_factor(int r, int c);
		int kmax, init, k, i, j, e, piv;
		longint best, m, p, t;
		logic [2:0] tp;
		kmax = int'(steps_reg) < r ? int'(steps_reg) : r;
		init = int'(init_reg) < r ? int'(init_reg) : r;
		for (i = 0; i < 8; i++) perm[i] = 3'(i);
		for (k = 0; k < c; k++) begin
			e = k < init ? init : r;
			piv = k;
			best = magn(lu_mat[k*8+k]);
			for (i = k + 1; i < e; i++) begin
				m = magn(lu_mat[i*8+k]);
				if (m > best) begin
					best = m;
					piv = i;
				end
			end
			tp = perm[k];
			perm[k] = perm[piv];
			perm[piv] = tp;
			for (j = 0; j < c; j++) begin
				t = lu_mat[k*8+j];
				lu_mat[k*8+j] = lu_mat[piv*8+j];
				lu_mat[piv*8+j] = t;
			end
			p = lu_mat[k*8+k];
			if (p == 0 || magn(p) < longint'(pmin_reg)) break;
			for (i = k + 1; i < r; i++)
				lu_mat[i*8+k] = sat32((lu_mat[i*8+k] * 65536) / p);
			for (i = k + 1; i < r; i++)
				for (j = k + 1; j < c; j++)
					lu_mat[i*8+j] = sat32(lu_mat[i*8+j] - qmul(lu_mat[i*8+k], lu_mat[k*8+j]));
			if (k >= kmax) break;
		end
		for (i = 0; i < r; i++)
			for (j = 0; j < c; j++)
				factor_q.push_back('{out_row: 3'(i), out_col: 3'(j),
					out_value: 32'(lu_mat[i*8+j]), orig_row: perm[i],
					steps_done: k[3:0], out_last: (i == r-1 && j == c-1)});
	endtask

	task automatic take_elem(tplu_pkg::elem_in_t d);
		int r, c;
		r = eff_rows();
		c = eff_cols(r);
		if (load_cnt < r * c) begin
			lu_mat[(load_cnt / c) * 8 + load_cnt % c] = longint'(d.elem_value);
			written[(load_cnt / c) * 8 + load_cnt % c] = 1;
			load_cnt++;
		end
		if (d.elem_last) begin
			load_cnt = 0;
			lu_factor(r, c);
		end
	endtask

	// called at a rising edge; returns at the edge where the item is taken
	task automatic send_elem(logic [31:0] v, bit last);
		tplu_pkg::elem_in_t d;
		d.elem_value = v;
		d.elem_last = last;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		take_elem(d);
		n_items++;
	endtask

	task automatic write_regs(logic [3:0] r, logic [3:0] c, logic [3:0] s, logic [3:0] ir,
			logic [15:0] pm);
		in_valid <= 1'b0;
		while (factor_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= tplu_pkg::CFG_ROWS;
		cfg_data <= 16'(r);
		@(posedge clk);
		cfg_index <= tplu_pkg::CFG_COLS;
		cfg_data <= 16'(c);
		@(posedge clk);
		cfg_index <= tplu_pkg::CFG_MAX_STEPS;
		cfg_data <= 16'(s);
		@(posedge clk);
		cfg_index <= tplu_pkg::CFG_INIT_ROWS;
		cfg_data <= 16'(ir);
		@(posedge clk);
		cfg_index <= tplu_pkg::CFG_PIVOT_MIN;
		cfg_data <= pm;
		@(posedge clk);
		cfg_we <= 1'b0;
		rows_reg = r;
		cols_reg = c;
		steps_reg = s;
		init_reg = ir;
		pmin_reg = pm;
	endtask

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 3))
			0: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
			1: return $urandom();
			2: begin
				case ($urandom_range(0, 4))
					0: return 32'h0;
					1: return 32'h7FFF_FFFF;
					2: return 32'h8000_0000;
					3: return 32'h1;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return 32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
		endcase
	endfunction

	function automatic bit all_written(int r, int c);
		for (int i = 0; i < r; i++)
			for (int j = 0; j < c; j++)
				if (!written[i*8+j]) return 0;
		return 1;
	endfunction

	// result checking and receiver stalls
	always @(posedge clk) begin
		tplu_pkg::result_t x;
		if (arst_n && out_valid && out_ready) begin
			if (factor_q.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual %p", $time, out_data);
				errors++;
			end else begin
				x = factor_q.pop_front();
				if (out_data.out_row !== x.out_row || out_data.out_col !== x.out_col
						|| out_data.out_value !== x.out_value
						|| out_data.orig_row !== x.orig_row
						|| out_data.steps_done !== x.steps_done
						|| out_data.out_last !== x.out_last) begin
					$display("%0t: mismatch, expected %p, actual %p", $time, x, out_data);
					errors++;
				end
			end
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else if (hold_req && out_valid) begin
			hold_req = 0;
			hold_cnt = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (rdy_burst > 0) begin
			rdy_burst--;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			rdy_burst = $urandom_range(0, 8);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		int r, c, cnt, mode, runs;
		errors = 0;
		n_items = 0;
		quiet = 0;
		hold_req = 0;
		hold_cnt = 0;
		rdy_burst = 0;
		load_cnt = 0;
		runs = 0;
		rows_reg = 8;
		cols_reg = 8;
		steps_reg = 8;
		init_reg = 0;
		pmin_reg = 1;
		for (int i = 0; i < 64; i++) begin
			lu_mat[i] = 0;
			written[i] = 0;
		end
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = tplu_pkg::CFG_ROWS;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].newcfg)
				write_regs(dir_tab[i].r, dir_tab[i].c, dir_tab[i].s, dir_tab[i].ir, dir_tab[i].pm);
			send_elem(dir_tab[i].v, dir_tab[i].last);
			if (dir_tab[i].chk) begin
				void'(factor_q.pop_back());
				factor_q.push_back('{out_row: 0, out_col: 0, out_value: dir_tab[i].xv,
					orig_row: 0, steps_done: dir_tab[i].xs, out_last: 1});
			end
		end

		while (n_items < ITEM_TARGET) begin
			case ($urandom_range(0, 7))
				0: r = $urandom_range(0, 15);
				1: r = 8;
				default: r = $urandom_range(1, 5);
			endcase
			c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 5);
			// the run after the held one keeps its settings so items are offered while stalled
			if (runs != HOLD_RUN + 1)
				write_regs(4'(r), 4'(c), 4'($urandom_range(0, 15)),
					($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(0, 15)),
					($urandom_range(0, 3) == 0) ? 16'($urandom()) :
					($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(0, 1)));
			r = eff_rows();
			c = eff_cols(r);
			mode = $urandom_range(0, 9);
			if (mode == 0 && all_written(r, c))
				cnt = $urandom_range(1, r * c);
			else if (mode == 1)
				cnt = r * c + $urandom_range(1, 3);
			else
				cnt = r * c;
			if (runs == HOLD_RUN)
				hold_req = 1;
			if (n_items > ITEM_TARGET - 60)
				quiet = 1;
			for (int i = 0; i < cnt; i++)
				send_elem(rand_elem(), i == cnt - 1);
			runs++;
		end
		in_valid <= 1'b0;

		while (factor_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
